// ----- src/vna_pkg.sv -----
// shared types and codes for the vertex normal accumulator
package vna_pkg;

  localparam int SumBits = 48;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_TRI  = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  typedef struct packed {
    logic        [1:0]  kind;
    logic        [11:0] index_a;
    logic        [11:0] index_b;
    logic        [11:0] index_c;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
  } in_item_t;

  typedef struct packed {
    logic signed [SumBits-1:0] sum_x;
    logic signed [SumBits-1:0] sum_y;
    logic signed [SumBits-1:0] sum_z;
    logic                      clipped;
  } result_t;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_TRI,
    OP_READ,
    OP_ZERO
  } op_e;

  typedef struct packed {
    op_e      op;
    in_item_t item;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_POS_RD,
    ST_POS_CAP,
    ST_DIFF,
    ST_MUL,
    ST_SUB,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_RD_ISSUE,
    ST_RD_OUT
  } back_state_e;

endpackage

// ----- src/vna_front.sv -----
// front end: takes items and classifies them into commands
module vna_front import vna_pkg::*; #(
  parameter int VERTEX_COUNT = 4096
) (
  input  logic      start_i,
  input  in_item_t  item_i,
  input  q_status_t q_status_i,
  input  logic      clearing_i,
  output logic      busy_o,
  output logic      push_o,
  output cmd_t      cmd_o
);

  logic a_ok, b_ok, c_ok;

  assign a_ok = 32'(item_i.index_a) < VERTEX_COUNT;
  assign b_ok = 32'(item_i.index_b) < VERTEX_COUNT;
  assign c_ok = 32'(item_i.index_c) < VERTEX_COUNT;

  assign busy_o = q_status_i.full | clearing_i;

  always_comb begin
    push_o      = 1'b0;
    cmd_o.item  = item_i;
    cmd_o.op    = OP_LOAD;
    case (item_i.kind)
      KIND_LOAD: begin
        cmd_o.op = OP_LOAD;
        push_o   = a_ok;
      end
      KIND_TRI: begin
        cmd_o.op = OP_TRI;
        push_o   = a_ok & b_ok & c_ok;
      end
      KIND_READ: begin
        cmd_o.op = a_ok ? OP_READ : OP_ZERO;
        push_o   = 1'b1;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
    push_o = push_o & start_i & ~busy_o;
  end

endmodule

// ----- src/vna_queue.sv -----
// four-entry command queue between front and back
module vna_queue import vna_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  cmd_t      cmd_i,
  input  logic      pop_i,
  output cmd_t      cmd_o,
  output q_status_t status_o
);

  cmd_t       slot_q [4];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] cnt_q;
  logic       do_push, do_pop;

  assign status_o.full  = (cnt_q == 3'd4);
  assign status_o.empty = (cnt_q == 3'd0);
  assign do_push = push_i & ~status_o.full;
  assign do_pop  = pop_i & ~status_o.empty;
  assign cmd_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 2'd1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 2'd1;
      cnt_q <= cnt_q + 3'(do_push) - 3'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= cmd_i;
  end

endmodule

// ----- src/vna_back.sv -----
// back end: position and normal memories, cross product and saturating sums
module vna_back import vna_pkg::*; #(
  parameter int VERTEX_COUNT = 4096,
  parameter int COORD_BITS   = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  input  q_status_t q_status_i,
  output logic      pop_o,
  output logic      clearing_o,
  output logic      result_valid_o,
  output result_t   result_o
);

  localparam int IW = $clog2(VERTEX_COUNT);
  localparam int CB = COORD_BITS;
  localparam int PW = 2 * CB + 2;
  localparam int NW = 2 * CB + 3;
  localparam int AW = ((NW > SumBits) ? NW : SumBits) + 1;

  back_state_e state_q, state_d;

  logic [IW-1:0] clr_q;
  logic [1:0]    k_q;
  cmd_t          cmd_q;

  logic [3*CB-1:0]  pos_mem [VERTEX_COUNT];
  logic [3*CB-1:0]  pos_rd_q;
  logic [3*CB-1:0]  p_q [3];
  logic signed [CB:0] u_q [3];
  logic signed [CB:0] v_q [3];
  logic signed [PW-1:0] prod0_q, prod1_q;
  logic signed [NW-1:0] n_q [3];

  logic [SumBits-1:0] nx_mem [VERTEX_COUNT];
  logic [SumBits-1:0] ny_mem [VERTEX_COUNT];
  logic [SumBits-1:0] nz_mem [VERTEX_COUNT];
  logic               cl_mem [VERTEX_COUNT];
  logic [SumBits-1:0] rdx_q, rdy_q, rdz_q;
  logic               rdc_q;

  logic            pos_we, pos_re, nrm_we, nrm_re;
  logic [IW-1:0]   pos_addr, nrm_addr;
  logic [3*CB-1:0] pos_wd;
  logic [SumBits-1:0] wdx, wdy, wdz;
  logic            wdc;
  logic [SumBits:0] sx, sy, sz;
  logic signed [CB:0] ma, mb, mc, md;

  function automatic logic [IW-1:0] to_addr(input logic [11:0] ix);
    logic [31:0] t;
    t = 32'(ix);
    return t[IW-1:0];
  endfunction

  function automatic logic [CB-1:0] to_coord(input logic signed [15:0] c);
    logic signed [31:0] t;
    t = 32'(c);
    return t[CB-1:0];
  endfunction

  // returns {clip, value}
  function automatic logic [SumBits:0] sat_add(input logic [SumBits-1:0] acc,
                                              input logic signed [NW-1:0] add);
    logic signed [AW-1:0] s, hi, lo;
    s  = AW'(signed'(acc)) + AW'(add);
    hi = AW'({1'b0, {(SumBits-1){1'b1}}});
    lo = ~hi;
    if (s > hi) return {1'b1, hi[SumBits-1:0]};
    if (s < lo) return {1'b1, lo[SumBits-1:0]};
    return {1'b0, s[SumBits-1:0]};
  endfunction

  logic [IW-1:0] corner;
  always_comb begin
    case (k_q)
      2'd0:    corner = to_addr(cmd_q.item.index_a);
      2'd1:    corner = to_addr(cmd_q.item.index_b);
      2'd2:    corner = to_addr(cmd_q.item.index_c);
      default: corner = to_addr(cmd_q.item.index_a);
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:    if (clr_q == IW'(VERTEX_COUNT - 1)) state_d = ST_IDLE;
      ST_IDLE:     if (!q_status_i.empty) state_d = ST_DISPATCH;
      ST_DISPATCH: begin
        case (cmd_q.op)
          OP_LOAD: state_d = ST_IDLE;
          OP_TRI:  state_d = ST_POS_RD;
          default: state_d = ST_RD_ISSUE;
        endcase
      end
      ST_POS_RD:   state_d = ST_POS_CAP;
      ST_POS_CAP:  state_d = (k_q == 2'd2) ? ST_DIFF : ST_POS_RD;
      ST_DIFF:     state_d = ST_MUL;
      ST_MUL:      state_d = ST_SUB;
      ST_SUB:      state_d = (k_q == 2'd2) ? ST_ACC_RD : ST_MUL;
      ST_ACC_RD:   state_d = ST_ACC_WR;
      ST_ACC_WR:   state_d = (k_q == 2'd2) ? ST_IDLE : ST_ACC_RD;
      ST_RD_ISSUE: state_d = ST_RD_OUT;
      ST_RD_OUT:   state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  assign sx = sat_add(rdx_q, n_q[0]);
  assign sy = sat_add(rdy_q, n_q[1]);
  assign sz = sat_add(rdz_q, n_q[2]);

  // outputs and memory controls
  always_comb begin
    pop_o          = 1'b0;
    clearing_o     = 1'b0;
    result_valid_o = 1'b0;
    pos_we   = 1'b0;
    pos_re   = 1'b0;
    pos_addr = corner;
    pos_wd   = {to_coord(cmd_q.item.coord_z), to_coord(cmd_q.item.coord_y),
                to_coord(cmd_q.item.coord_x)};
    nrm_we   = 1'b0;
    nrm_re   = 1'b0;
    nrm_addr = corner;
    wdx = sx[SumBits-1:0];
    wdy = sy[SumBits-1:0];
    wdz = sz[SumBits-1:0];
    wdc = rdc_q | sx[SumBits] | sy[SumBits] | sz[SumBits];
    case (state_q)
      ST_CLEAR: begin
        clearing_o = 1'b1;
        nrm_we   = 1'b1;
        nrm_addr = clr_q;
        wdx = '0;
        wdy = '0;
        wdz = '0;
        wdc = 1'b0;
      end
      ST_IDLE:     pop_o  = ~q_status_i.empty;
      ST_DISPATCH: pos_we = (cmd_q.op == OP_LOAD);
      ST_POS_RD:   pos_re = 1'b1;
      ST_ACC_RD:   nrm_re = 1'b1;
      ST_ACC_WR:   nrm_we = 1'b1;
      ST_RD_ISSUE: nrm_re = 1'b1;
      ST_RD_OUT:   result_valid_o = 1'b1;
      default: begin
      end
    endcase
  end

  always_comb begin
    case (k_q)
      2'd0: begin
        ma = u_q[1]; mb = v_q[2]; mc = u_q[2]; md = v_q[1];
      end
      2'd1: begin
        ma = u_q[2]; mb = v_q[0]; mc = u_q[0]; md = v_q[2];
      end
      default: begin
        ma = u_q[0]; mb = v_q[1]; mc = u_q[1]; md = v_q[0];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + IW'(1);
      if (state_q == ST_POS_CAP || state_q == ST_SUB || state_q == ST_ACC_WR) begin
        k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cmd_q <= cmd_i;
    if (state_q == ST_POS_CAP) p_q[k_q] <= pos_rd_q;
    if (state_q == ST_DIFF) begin
      for (int j = 0; j < 3; j++) begin
        u_q[j] <= (CB+1)'(signed'(p_q[1][j*CB +: CB])) - (CB+1)'(signed'(p_q[0][j*CB +: CB]));
        v_q[j] <= (CB+1)'(signed'(p_q[2][j*CB +: CB])) - (CB+1)'(signed'(p_q[0][j*CB +: CB]));
      end
    end
    if (state_q == ST_MUL) begin
      prod0_q <= ma * mb;
      prod1_q <= mc * md;
    end
    if (state_q == ST_SUB) n_q[k_q] <= NW'(prod0_q) - NW'(prod1_q);
  end

  // position memory
  always_ff @(posedge clk_i) begin
    if (pos_we) pos_mem[pos_addr] <= pos_wd;
    if (pos_re) pos_rd_q <= pos_mem[pos_addr];
  end

  // normal sum memories
  always_ff @(posedge clk_i) begin
    if (nrm_we) begin
      nx_mem[nrm_addr] <= wdx;
      ny_mem[nrm_addr] <= wdy;
      nz_mem[nrm_addr] <= wdz;
      cl_mem[nrm_addr] <= wdc;
    end
    if (nrm_re) begin
      rdx_q <= nx_mem[nrm_addr];
      rdy_q <= ny_mem[nrm_addr];
      rdz_q <= nz_mem[nrm_addr];
      rdc_q <= cl_mem[nrm_addr];
    end
  end

  always_comb begin
    if (cmd_q.op == OP_ZERO) begin
      result_o = '0;
    end else begin
      result_o.sum_x   = rdx_q;
      result_o.sum_y   = rdy_q;
      result_o.sum_z   = rdz_q;
      result_o.clipped = rdc_q;
    end
  end

endmodule

// ----- src/vertex_normal_accumulator.sv -----
// top level: area-weighted vertex normal accumulator
// steps from acceptance with the back end idle: a load is popped, then written at dispatch;
// a triangle goes through pop, dispatch, three position reads (read, capture), difference,
// three multiply/subtract steps and three sum updates (read, write)
// read: pop, dispatch and read issue, then the result strobe, one cycle wide, no stall;
// the back end works on one item at a time, a four-entry queue takes items meanwhile
// after reset busy_o stays high while the sums are cleared
module vertex_normal_accumulator import vna_pkg::*; #(
  parameter int VERTEX_COUNT = 4096,
  parameter int COORD_BITS   = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  input  in_item_t item_i,
  output logic     result_valid_o,
  output result_t  result_o
);

  // front to queue
  logic      push;
  cmd_t      push_cmd;
  // queue to back
  cmd_t      head_cmd;
  q_status_t q_status;
  logic      pop;
  logic      clearing;

  // classification: drops bad loads, bad triangles and unknown kinds
  vna_front #(
    .VERTEX_COUNT(VERTEX_COUNT)
  ) u_front (
    .start_i    (start_i),
    .item_i     (item_i),
    .q_status_i (q_status),
    .clearing_i (clearing),
    .busy_o     (busy_o),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  vna_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (push_cmd),
    .pop_i    (pop),
    .cmd_o    (head_cmd),
    .status_o (q_status)
  );

  // execution: memories, cross product, saturating accumulation
  vna_back #(
    .VERTEX_COUNT(VERTEX_COUNT),
    .COORD_BITS  (COORD_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (head_cmd),
    .q_status_i     (q_status),
    .pop_o          (pop),
    .clearing_o     (clearing),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

// ----- test/vertex_normal_accumulator_tb.sv -----
// testbench for the vertex normal accumulator: queued driver, predictor and result monitor
`timescale 1ns / 100ps

module vertex_normal_accumulator_tb;
  import vna_pkg::*;

  localparam int NumVerts   = 4096;
  localparam int HammerTris = 16;      // a short run of max-area triangles
  localparam int RandItems  = 860;
  localparam longint CycleLimit = 3000000;
  localparam longint SumHi = (longint'(1) << 47) - 1;
  localparam longint SumLo = -(longint'(1) << 47);

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start_i = 1'b0;
  logic     busy_o;
  in_item_t item_i = '0;
  logic     result_valid_o;
  result_t  result_o;

  vertex_normal_accumulator dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .item_i, .result_valid_o, .result_o
  );

  always #2 clk_i = ~clk_i;

  // items waiting to be driven, filled up front by the stimulus block
  in_item_t pending_items[$];
  // sums that the read items still have to return, oldest first
  result_t  expected_sums[$];

  // predicted block state
  int     vert_x[NumVerts], vert_y[NumVerts], vert_z[NumVerts];
  longint norm_x[NumVerts], norm_y[NumVerts], norm_z[NumVerts];
  bit     clip_mark[NumVerts];

  // generator-side view of which positions have been loaded
  bit gen_loaded[NumVerts];
  int loaded_list[$];

  int     items_taken = 0;
  int     phase1_end = 0, phase2_end = 0;
  int     n_errors = 0, n_sums_checked = 0, n_tris = 0, n_clipped_seen = 0;
  longint cycle_count = 0;

  // saturating add of one component, marks the clip flag on overflow
  function automatic longint clamp_add(longint acc, longint add, ref bit clipped);
    longint r;
    r = acc + add;
    if (r > SumHi) begin
      clipped = 1'b1;
      return SumHi;
    end
    if (r < SumLo) begin
      clipped = 1'b1;
      return SumLo;
    end
    return r;
  endfunction

  function automatic void add_to_vertex(int v, longint nx, longint ny, longint nz);
    bit clipped;
    clipped = 1'b0;
    norm_x[v] = clamp_add(norm_x[v], nx, clipped);
    norm_y[v] = clamp_add(norm_y[v], ny, clipped);
    norm_z[v] = clamp_add(norm_z[v], nz, clipped);
    if (clipped) clip_mark[v] = 1'b1;
  endfunction

  // update the predicted state for one accepted item
  function automatic void accumulate_item(in_item_t it);
    int a, b, c;
    longint ux, uy, uz, vx, vy, vz;
    result_t r;
    a = int'(it.index_a);
    b = int'(it.index_b);
    c = int'(it.index_c);
    case (it.kind)
      KIND_LOAD: begin
        vert_x[a] = int'(it.coord_x);
        vert_y[a] = int'(it.coord_y);
        vert_z[a] = int'(it.coord_z);
      end
      KIND_TRI: begin
        ux = vert_x[b] - vert_x[a];
        uy = vert_y[b] - vert_y[a];
        uz = vert_z[b] - vert_z[a];
        vx = vert_x[c] - vert_x[a];
        vy = vert_y[c] - vert_y[a];
        vz = vert_z[c] - vert_z[a];
        // corners updated in order a, b, c, each saturating on its own
        add_to_vertex(a, uy * vz - uz * vy, uz * vx - ux * vz, ux * vy - uy * vx);
        add_to_vertex(b, uy * vz - uz * vy, uz * vx - ux * vz, ux * vy - uy * vx);
        add_to_vertex(c, uy * vz - uz * vy, uz * vx - ux * vz, ux * vy - uy * vx);
        n_tris++;
      end
      KIND_READ: begin
        r.sum_x   = norm_x[a][47:0];
        r.sum_y   = norm_y[a][47:0];
        r.sum_z   = norm_z[a][47:0];
        r.clipped = clip_mark[a];
        expected_sums.insert(expected_sums.size(), r);
      end
      default: ;  // unknown kind does nothing
    endcase
  endfunction

  function automatic void queue_item(logic [1:0] k, int a, int b, int c,
                                     int x, int y, int z);
    in_item_t it;
    it.kind    = k;
    it.index_a = a[11:0];
    it.index_b = b[11:0];
    it.index_c = c[11:0];
    it.coord_x = x[15:0];
    it.coord_y = y[15:0];
    it.coord_z = z[15:0];
    if (k == KIND_LOAD && !gen_loaded[a]) begin
      gen_loaded[a] = 1'b1;
      loaded_list.insert(loaded_list.size(), a);
    end
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic int any_loaded();
    return loaded_list[$urandom_range(loaded_list.size() - 1)];
  endfunction

  // driver: present the next item, hold it until the block takes it
  always @(posedge clk_i) begin
    int idle_pct;
    if (rst_ni && (!start_i || !busy_o)) begin
      if (start_i) begin
        accumulate_item(item_i);
        items_taken++;
      end
      // sender gap rate follows the phase of the run
      idle_pct = (items_taken < phase1_end) ? 14 : (items_taken < phase2_end) ? 53 : 0;
      if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
        item_i  <= pending_items.pop_front();
        start_i <= 1'b1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor: every strobed result against the oldest expected sum
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_sums.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("unexpected result: %p", result_o);
      end else begin
        want = expected_sums.pop_front();
        n_sums_checked++;
        if (want.clipped) n_clipped_seen++;
        if (result_o !== want) begin
          n_errors++;
          if (n_errors <= 10)
            $display("sum mismatch: expected x=%h y=%h z=%h clip=%b, got x=%h y=%h z=%h clip=%b",
                     want.sum_x, want.sum_y, want.sum_z, want.clipped,
                     result_o.sum_x, result_o.sum_y, result_o.sum_z, result_o.clipped);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("vertex_normal_accumulator_tb NOT OK");
      $finish;
    end
  end

  initial begin
    int pool[24];
    int n_dir, r, a, b, c;
    for (int i = 0; i < NumVerts; i++) begin
      vert_x[i] = 0; vert_y[i] = 0; vert_z[i] = 0;
      norm_x[i] = 0; norm_y[i] = 0; norm_z[i] = 0;
      clip_mark[i] = 1'b0;
      gen_loaded[i] = 1'b0;
    end

    // directed: extremes, every kind, unloaded reads, repeated corners
    queue_item(KIND_READ, 0, 0, 0, 0, 0, 0);
    queue_item(KIND_READ, 4095, 4095, 4095, -1, -1, -1);
    queue_item(KIND_LOAD, 0, 4095, 4095, -32768, -32768, -32768);
    queue_item(KIND_LOAD, 4095, 0, 0, 32767, 32767, 32767);
    queue_item(KIND_LOAD, 2730, 1365, 2730, 32767, -32768, 0);
    queue_item(KIND_LOAD, 1365, 2730, 1365, -1, 0, 1);
    queue_item(KIND_TRI, 0, 4095, 2730, 0, 0, 0);
    queue_item(KIND_TRI, 4095, 2730, 1365, -1, -1, -1);
    queue_item(KIND_TRI, 0, 0, 4095, 0, 0, 0);        // repeated corner
    queue_item(KIND_TRI, 1365, 1365, 1365, 0, 0, 0);  // all corners the same
    queue_item(2'd3, 4095, 4095, 4095, -1, -1, -1);   // unknown kind
    queue_item(KIND_READ, 0, 0, 0, 0, 0, 0);
    queue_item(KIND_READ, 4095, 0, 0, 0, 0, 0);
    queue_item(KIND_READ, 2730, 0, 0, 0, 0, 0);
    queue_item(KIND_READ, 1365, 0, 0, 0, 0, 0);
    n_dir = pending_items.size();
    phase1_end = n_dir + RandItems / 3;
    phase2_end = n_dir + 2 * RandItems / 3;

    // random: mostly a small pool of vertices so triangles and reads hit loaded data
    for (int i = 0; i < 24; i++) pool[i] = $urandom_range(NumVerts - 1);
    for (int i = 0; i < RandItems; i++) begin
      r = $urandom_range(99);
      a = ($urandom_range(9) < 9) ? pool[$urandom_range(23)] : $urandom_range(NumVerts - 1);
      if (r < 28) begin
        queue_item(KIND_LOAD, a, $urandom_range(4095), $urandom_range(4095),
                   $urandom_range(65535), $urandom_range(65535), $urandom_range(65535));
      end else if (r < 62) begin
        a = any_loaded();
        b = any_loaded();
        c = any_loaded();
        queue_item(KIND_TRI, a, b, c, $urandom_range(65535), $urandom_range(65535),
                   $urandom_range(65535));
      end else if (r < 95) begin
        if ($urandom_range(1)) a = any_loaded();
        queue_item(KIND_READ, a, $urandom_range(4095), $urandom_range(4095),
                   $urandom_range(65535), $urandom_range(65535), $urandom_range(65535));
      end else begin
        queue_item(2'd3, $urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                   $urandom_range(65535), $urandom_range(65535), $urandom_range(65535));
      end
    end

    // max-area triangle repeated: large cross products push z up and y down
    queue_item(KIND_LOAD, 7, 0, 0, -32768, -32768, -32768);
    queue_item(KIND_LOAD, 8, 0, 0, 32767, -32768, -32768);
    queue_item(KIND_LOAD, 9, 0, 0, -32768, 32767, 32767);
    for (int i = 0; i < HammerTris; i++) begin
      queue_item(KIND_TRI, 7, 8, 9, 0, 0, 0);
      if (i % 8192 == 0) queue_item(KIND_READ, 8, 0, 0, 0, 0, 0);
    end
    queue_item(KIND_READ, 7, 0, 0, 0, 0, 0);
    queue_item(KIND_READ, 8, 0, 0, 0, 0, 0);
    queue_item(KIND_READ, 9, 0, 0, 0, 0, 0);
    // reversed orientation pulls the sums back toward zero
    queue_item(KIND_TRI, 7, 9, 8, 0, 0, 0);
    queue_item(KIND_READ, 7, 0, 0, 0, 0, 0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // drain: everything driven and every expected sum returned
    wait (pending_items.size() == 0 && !start_i && expected_sums.size() == 0);
    repeat (40) @(posedge clk_i);

    $display("%0d items taken (%0d triangles), %0d sums checked, %0d of them clipped",
             items_taken, n_tris, n_sums_checked, n_clipped_seen);
    $display("%0d mismatches", n_errors);
    if (n_errors == 0 && expected_sums.size() == 0) begin
      $display("vertex_normal_accumulator_tb OK");
    end else begin
      $display("vertex_normal_accumulator_tb NOT OK");
    end
    $finish;
  end

endmodule
